// ===== rtl/uer_pkg.sv =====
// Shared constants, types and command/status bundles for the echo ranger.
`default_nettype none
package uer_pkg;

   // Tick timing and counter sizing
   localparam int unsigned TICK_HZ    = 1000000;
   localparam int unsigned TRIG_TICKS = 10;
   localparam int unsigned COUNT_BITS = 16;

   localparam int unsigned TICK_DIV = TICK_HZ / 1000;
   localparam int unsigned TRIG_W   = $clog2(TRIG_TICKS + 1);
   localparam int unsigned CNT_W    = (COUNT_BITS > TRIG_W) ? COUNT_BITS : TRIG_W;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

   // Result field widths
   localparam int unsigned US_W = 16;
   localparam int unsigned CM_W = 11;

   // Serial divider sizing: us*100 as dividend, speed of sound as divisor
   localparam int unsigned DIV_W  = US_W + 7;
   localparam int unsigned DVS_W  = 12;
   localparam int unsigned DCNT_W = $clog2(DIV_W + 1);

   // Count to microseconds: n/TICK_DIV as (n*US_RECIP)>>US_SHIFT with
   // n = count*1000, exact for n below 2^UN_W
   localparam int unsigned UN_W       = COUNT_BITS + 10;
   localparam int unsigned US_SHIFT   = UN_W + $clog2(TICK_DIV);
   localparam logic [63:0] US_RECIP_V =
      ((64'd1 << US_SHIFT) + 64'(TICK_DIV) - 64'd1) / 64'(TICK_DIV);
   localparam int unsigned US_RECIP_W = $clog2(US_RECIP_V + 64'd1);
   localparam logic [US_RECIP_W-1:0] US_RECIP = US_RECIP_W'(US_RECIP_V);
   localparam int unsigned US_PROD_W  = UN_W + US_RECIP_W;
   localparam int unsigned UQ_W       =
      ((US_PROD_W - US_SHIFT) > (US_W + 1)) ? (US_PROD_W - US_SHIFT) : (US_W + 1);

   // Speed of sound in dm/s: a = 3313 + 6*t, spd = a - (a/100)*15
   localparam int unsigned TEMP_W      = 7;
   localparam logic [TEMP_W-1:0] TEMP_RESET = 7'd22;
   localparam int unsigned SPD_W       = 12;
   localparam logic [SPD_W-1:0] SPD_BASE = 12'd3313;
   // a/100 as (a*1311)>>17, exact for a below 4096
   localparam int unsigned RECIP_W     = 11;
   localparam logic [RECIP_W-1:0] RECIP_100 = 11'd1311;
   localparam int unsigned RECIP_SHIFT = 17;
   localparam int unsigned PROD_W      = SPD_W + RECIP_W;
   localparam int unsigned QUO100_W    = PROD_W - RECIP_SHIFT;

   // Register port
   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;
   localparam logic REG_TEMPERATURE = 1'b0;   // word index of temperature_c

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_WAIT = 4'b0100,
      PH_MEAS = 4'b1000
   } phase_type;

   typedef enum logic [3:0] {
      ST_TICK   = 4'b0001,
      ST_DIV_US = 4'b0010,
      ST_DIV_CM = 4'b0100,
      ST_EMIT   = 4'b1000
   } ctrl_state_type;

   typedef enum logic [2:0] {
      CNT_HOLD  = 3'd0,
      CNT_CLEAR = 3'd1,
      CNT_ONE   = 3'd2,
      CNT_INC   = 3'd3,
      CNT_WRAP  = 3'd4
   } cnt_op_type;

   typedef struct packed {
      cnt_op_type cnt_op;
      logic       capture;
      logic       res_trig;
      logic       res_busy;
      logic       res_done;
      logic       res_noecho;
      logic       div_us_start;
      logic       latch_us;
      logic       div_cm_start;
      logic       latch_cm;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic trig_reached;
      logic wrap_at_max;
      logic us_ready;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/uer_div.sv =====
// Restoring serial divider, one quotient bit per clock.
`default_nettype none
module uer_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [uer_pkg::DIV_W-1:0] dividend,
   input  wire logic [uer_pkg::DVS_W-1:0] divisor,
   output logic      [uer_pkg::DIV_W-1:0] quotient,
   output logic                           done
);
   import uer_pkg::*;

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    shifted;
   logic [DVS_W+1:0]  diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[DVS_W+1]) begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== rtl/uer_datapath.sv =====
// Tick counter, speed-of-sound pipeline, count-to-microseconds conversion, divider, result and output registers.
`default_nettype none
module uer_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire uer_pkg::cmd_type           cmd,
   output uer_pkg::status_type             status,
   input  wire logic [uer_pkg::TEMP_W-1:0] temperature,
   output logic                            rsp_trigger_out,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic                            rsp_no_echo,
   output logic      [uer_pkg::US_W-1:0]   rsp_echo_us,
   output logic      [uer_pkg::CM_W-1:0]   rsp_distance_cm
);
   import uer_pkg::*;

   // Tick counter
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W:0]   cnt_inc;
   logic [CNT_W-1:0] cnt_wrap;

   assign cnt_inc  = {1'b0, cnt_ff} + 1'b1;
   assign cnt_wrap = cnt_inc[CNT_W-1:0] & CNT_MAX;

   always_comb begin
      case (cmd.cnt_op)
         CNT_HOLD:  cnt_in = cnt_ff;
         CNT_CLEAR: cnt_in = '0;
         CNT_ONE:   cnt_in = CNT_W'(1);
         CNT_INC:   cnt_in = cnt_inc[CNT_W-1:0];
         CNT_WRAP:  cnt_in = cnt_wrap;
         default:   cnt_in = '0;
      endcase
   end

   // Speed of sound, two registered steps from the temperature register
   logic [SPD_W-1:0]    a_ff, a_in;
   logic [SPD_W-1:0]    spd_ff, spd_in;
   logic [PROD_W-1:0]   a_prod;
   logic [QUO100_W-1:0] a_hund;
   logic [SPD_W-1:0]    a_hund15;

   always_comb begin
      a_in     = SPD_BASE + SPD_W'({temperature, 2'b00}) + SPD_W'({temperature, 1'b0});
      a_prod   = PROD_W'(a_ff) * PROD_W'(RECIP_100);
      a_hund   = a_prod[PROD_W-1:RECIP_SHIFT];
      a_hund15 = SPD_W'({a_hund, 4'b0000}) - SPD_W'(a_hund);
      spd_in   = a_ff - a_hund15;
   end

   // Count to microseconds: count*1000 registered, then reciprocal multiply
   logic [UN_W-1:0]      cnt_ext;
   logic [UN_W-1:0]      us_num_ff, us_num_in;
   logic [US_PROD_W-1:0] us_prod;
   logic [UQ_W-1:0]      us_quo_ff, us_quo_in;
   logic [1:0]           us_pipe_ff, us_pipe_in;
   logic [US_W-1:0]      us_sat;

   always_comb begin
      cnt_ext = UN_W'(cnt_wrap[COUNT_BITS-1:0]);
      if (cmd.div_us_start) begin
         us_num_in = (cnt_ext << 10) - (cnt_ext << 4) - (cnt_ext << 3);
      end else begin
         us_num_in = us_num_ff;
      end
      us_prod    = US_PROD_W'(us_num_ff) * US_PROD_W'(US_RECIP);
      us_quo_in  = UQ_W'(us_prod >> US_SHIFT);
      us_pipe_in = {us_pipe_ff[0], cmd.div_us_start};
      us_sat     = (|us_quo_ff[UQ_W-1:US_W]) ? {US_W{1'b1}} : us_quo_ff[US_W-1:0];
   end

   // Divider feed: us*100 / speed
   logic [DIV_W-1:0] div_quo;
   logic             div_done;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] us_ext;

   always_comb begin
      us_ext       = DIV_W'(us_sat);
      div_dividend = (us_ext << 6) + (us_ext << 5) + (us_ext << 2);
   end

   uer_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_cm_start),
      .dividend (div_dividend),
      .divisor  (DVS_W'(spd_ff)),
      .quotient (div_quo),
      .done     (div_done)
   );

   // Per-tick result and held measurement
   logic            res_trig_ff, res_trig_in;
   logic            res_busy_ff, res_busy_in;
   logic            res_done_ff, res_done_in;
   logic            res_noecho_ff, res_noecho_in;
   logic [US_W-1:0] last_us_ff, last_us_in;
   logic [CM_W-1:0] last_cm_ff, last_cm_in;

   always_comb begin
      res_trig_in   = res_trig_ff;
      res_busy_in   = res_busy_ff;
      res_done_in   = res_done_ff;
      res_noecho_in = res_noecho_ff;
      last_us_in    = last_us_ff;
      last_cm_in    = last_cm_ff;
      if (cmd.capture) begin
         res_trig_in   = cmd.res_trig;
         res_busy_in   = cmd.res_busy;
         res_done_in   = cmd.res_done;
         res_noecho_in = cmd.res_noecho;
         if (cmd.res_noecho) begin
            last_us_in = '0;
            last_cm_in = '0;
         end
      end
      if (cmd.latch_us) begin
         last_us_in = us_sat;
      end
      if (cmd.latch_cm) begin
         // halve and keep 11 bits
         last_cm_in = div_quo[CM_W:1];
      end
   end

   // Output register
   logic            out_trig_ff, out_trig_in;
   logic            out_busy_ff, out_busy_in;
   logic            out_done_ff, out_done_in;
   logic            out_noecho_ff, out_noecho_in;
   logic [US_W-1:0] out_us_ff, out_us_in;
   logic [CM_W-1:0] out_cm_ff, out_cm_in;

   always_comb begin
      out_trig_in   = out_trig_ff;
      out_busy_in   = out_busy_ff;
      out_done_in   = out_done_ff;
      out_noecho_in = out_noecho_ff;
      out_us_in     = out_us_ff;
      out_cm_in     = out_cm_ff;
      if (cmd.emit) begin
         out_trig_in   = res_trig_ff;
         out_busy_in   = res_busy_ff;
         out_done_in   = res_done_ff;
         out_noecho_in = res_noecho_ff;
         out_us_in     = last_us_ff;
         out_cm_in     = last_cm_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      spd_ff        <= spd_in;
      us_num_ff     <= us_num_in;
      us_quo_ff     <= us_quo_in;
      res_trig_ff   <= res_trig_in;
      res_busy_ff   <= res_busy_in;
      res_done_ff   <= res_done_in;
      res_noecho_ff <= res_noecho_in;
      out_trig_ff   <= out_trig_in;
      out_busy_ff   <= out_busy_in;
      out_done_ff   <= out_done_in;
      out_noecho_ff <= out_noecho_in;
      out_us_ff     <= out_us_in;
      out_cm_ff     <= out_cm_in;
      if (reset) begin
         cnt_ff     <= '0;
         us_pipe_ff <= '0;
         last_us_ff <= '0;
         last_cm_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         us_pipe_ff <= us_pipe_in;
         last_us_ff <= last_us_in;
         last_cm_ff <= last_cm_in;
      end
   end

   assign status.trig_reached = (cnt_inc >= (CNT_W + 1)'(TRIG_TICKS));
   assign status.wrap_at_max  = (cnt_wrap == CNT_MAX);
   assign status.us_ready     = us_pipe_ff[1];
   assign status.div_done     = div_done;

   assign rsp_trigger_out = out_trig_ff;
   assign rsp_busy_res    = out_busy_ff;
   assign rsp_done_res    = out_done_ff;
   assign rsp_no_echo     = out_noecho_ff;
   assign rsp_echo_us     = out_us_ff;
   assign rsp_distance_cm = out_cm_ff;

endmodule
`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// Ranging phase and sequencing controller.
`default_nettype none
module uer_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_start_req,
   input  wire logic                req_echo_level,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire uer_pkg::status_type status,
   output uer_pkg::cmd_type         cmd
);
   import uer_pkg::*;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           finish;

   assign req_stall = (state_ff != ST_TICK);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cmd          = '{cnt_op: CNT_HOLD, default: 1'b0};
      state_in     = state_ff;
      phase_in     = phase_ff;
      finish       = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      case (state_ff)
         ST_TICK: begin
            if (accept) begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (req_start_req) begin
                        cmd.res_trig = 1'b1;
                        if (TRIG_TICKS <= 1) begin
                           phase_in   = PH_WAIT;
                           cmd.cnt_op = CNT_CLEAR;
                        end else begin
                           phase_in   = PH_TRIG;
                           cmd.cnt_op = CNT_ONE;
                        end
                     end
                  end
                  PH_TRIG: begin
                     cmd.res_trig = 1'b1;
                     if (status.trig_reached) begin
                        phase_in   = PH_WAIT;
                        cmd.cnt_op = CNT_CLEAR;
                     end else begin
                        cmd.cnt_op = CNT_INC;
                     end
                  end
                  PH_WAIT: begin
                     if (req_echo_level) begin
                        phase_in   = PH_MEAS;
                        cmd.cnt_op = CNT_CLEAR;
                     end else if (status.wrap_at_max) begin
                        cmd.res_done   = 1'b1;
                        cmd.res_noecho = 1'b1;
                        phase_in       = PH_IDLE;
                        cmd.cnt_op     = CNT_CLEAR;
                     end else begin
                        cmd.cnt_op = CNT_WRAP;
                     end
                  end
                  PH_MEAS: begin
                     // falling edge wins over overflow
                     if (!req_echo_level) begin
                        cmd.res_done     = 1'b1;
                        cmd.div_us_start = 1'b1;
                        finish           = 1'b1;
                        phase_in         = PH_IDLE;
                        cmd.cnt_op       = CNT_CLEAR;
                     end else if (status.wrap_at_max) begin
                        cmd.res_done   = 1'b1;
                        cmd.res_noecho = 1'b1;
                        phase_in       = PH_IDLE;
                        cmd.cnt_op     = CNT_CLEAR;
                     end else begin
                        cmd.cnt_op = CNT_WRAP;
                     end
                  end
                  default: begin
                     phase_in   = PH_IDLE;
                     cmd.cnt_op = CNT_CLEAR;
                  end
               endcase
               cmd.res_busy = (phase_in != PH_IDLE);
               cmd.capture  = 1'b1;
               state_in     = finish ? ST_DIV_US : ST_EMIT;
            end
         end
         ST_DIV_US: begin
            if (status.us_ready) begin
               cmd.latch_us     = 1'b1;
               cmd.div_cm_start = 1'b1;
               state_in         = ST_DIV_CM;
            end
         end
         ST_DIV_CM: begin
            if (status.div_done) begin
               cmd.latch_cm = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_TICK;
            end
         end
         default: begin
            state_in = ST_TICK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TICK;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
// Top level of the ultrasonic echo ranger: register port, controller and datapath.
`default_nettype none
// Each req item is one timer tick carrying a start request and the sampled
// echo pin level; every item gives exactly one rsp item with the trigger
// level, busy/done/no-echo flags and the last measured pulse length (us) and
// one-way distance (cm). A start from idle raises the trigger for TRIG_TICKS
// ticks, the echo rising edge clears the tick counter and the falling edge
// captures it; a counter reaching 2^COUNT_BITS-1 first ends the measurement
// with no_echo and zero results. An ordinary tick is accepted, and its result
// is then loaded into the output register. The tick that ends a measurement
// on the echo falling edge turns the count into microseconds with a
// registered reciprocal multiply, then runs us*100/speed through a restoring
// divider at one quotient bit per cycle. The speed of sound is derived from
// temperature_c (register 0, byte address 0, reset 22 C) in a short pipeline,
// so the register may be written whenever the block is idle. The result sits
// in an output register; the next tick is taken while a result is still
// waiting, and only the hand-over of a new result waits on rsp_stall.
module ultrasonic_echo_ranger_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // tick items
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_start_req,
   input  wire logic                        req_echo_level,
   // result items
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_trigger_out,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic                             rsp_no_echo,
   output logic      [uer_pkg::US_W-1:0]    rsp_echo_us,
   output logic      [uer_pkg::CM_W-1:0]    rsp_distance_cm,
   // register port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [uer_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [uer_pkg::DATA_W-1:0]  pwdata,
   output logic      [uer_pkg::DATA_W-1:0]  prdata,
   output logic                             pready
);
   import uer_pkg::*;

   // temperature_c register; word index taken from the top address bit
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic              temp_sel;
   logic              temp_wr;

   assign pready   = 1'b1;
   assign temp_sel = (paddr[ADDR_W-1] == REG_TEMPERATURE);
   assign temp_wr  = psel & penable & pwrite & pready & temp_sel;
   assign temp_in  = temp_wr ? pwdata[TEMP_W-1:0] : temp_ff;
   assign prdata   = temp_sel ? DATA_W'(temp_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= TEMP_RESET;
      end else begin
         temp_ff <= temp_in;
      end
   end

   cmd_type    cmd;
   status_type status;

   uer_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_start_req  (req_start_req),
      .req_echo_level (req_echo_level),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   uer_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .temperature     (temp_ff),
      .rsp_trigger_out (rsp_trigger_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_no_echo     (rsp_no_echo),
      .rsp_echo_us     (rsp_echo_us),
      .rsp_distance_cm (rsp_distance_cm)
   );

endmodule
`default_nettype wire
